// ----- sv/rqcrs_pkg.sv -----
// Shared types and constants for the report queue credit/retry sender.
// No dependencies; used by every module of the block except rqcrs_ram.
package rqcrs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [COUNT_W-1:0] RETRY_IDLE        = 8'hFF;
  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST   = 7'd3;
  localparam logic [COUNT_W-1:0] CREDIT_DEFAULT_RST = 8'd255;
  localparam logic [COUNT_W-1:0] CREDIT_DROP_RST   = 8'd8;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

  typedef enum logic [1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_SEND  = 2'd1,
    FUNC_UNACK = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    OUTC_OK   = 2'd0,
    OUTC_BUSY = 2'd1,
    OUTC_ERR  = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RETRY_LIMIT    = 2'd0,
    CFG_CREDIT_DEFAULT = 2'd1,
    CFG_CREDIT_DROP    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ENQ,
    CMD_SEND,
    CMD_UNACK
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [KIND_W-1:0]  report_kind;
    logic [DATA_W-1:0]  report_data;
    logic               link_up;
    logic [1:0]         send_outcome;
    logic [COUNT_W-1:0] unacked_count;
  } in_item_t;

  typedef struct packed {
    logic              enqueue_accepted;
    logic              send_valid;
    logic [KIND_W-1:0] send_kind;
    logic [DATA_W-1:0] send_data;
    logic              report_dropped;
    logic              work_waiting;
  } out_item_t;

  typedef struct packed {
    cmd_op_e            op;
    logic [KIND_W-1:0]  report_kind;
    logic [DATA_W-1:0]  report_data;
    logic [1:0]         send_outcome;
    logic [COUNT_W-1:0] unacked_count;
  } cmd_t;

endpackage

// ----- sv/rqcrs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rqcrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/rqcrs_front.sv -----
// Front end: classifies input items into commands and buffers them two deep.
// Depends on rqcrs_pkg.
module rqcrs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rqcrs_pkg::in_item_t item_i,
  output logic                full_o,
  output logic                cmd_valid_o,
  output rqcrs_pkg::cmd_t     cmd_o,
  input  logic                cmd_pop_i
);
  import rqcrs_pkg::*;

  cmd_t       cmd_in;
  cmd_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    cmd_in               = '0;
    cmd_in.op            = CMD_NONE;
    cmd_in.report_kind   = item_i.report_kind;
    cmd_in.report_data   = item_i.report_data;
    cmd_in.send_outcome  = item_i.send_outcome;
    cmd_in.unacked_count = item_i.unacked_count;
    case (item_i.func)
      FUNC_ENQ:   cmd_in.op = CMD_ENQ;
      FUNC_SEND:  if (item_i.link_up) cmd_in.op = CMD_SEND;
      FUNC_UNACK: if (item_i.link_up) cmd_in.op = CMD_UNACK;
      default:    cmd_in.op = CMD_NONE;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= cmd_in;
    end
  end

endmodule

// ----- sv/rqcrs_back.sv -----
// Back end: report ring, credit and retry bookkeeping; executes one command at a time.
// Depends on rqcrs_pkg and rqcrs_ram.
module rqcrs_back #(
  parameter int unsigned QUEUE_DEPTH  = rqcrs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = rqcrs_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rqcrs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rqcrs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                cmd_valid_i,
  input  rqcrs_pkg::cmd_t                     cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output rqcrs_pkg::out_item_t                res_o
);
  import rqcrs_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned EW = PAYLOAD_BITS + KIND_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  typedef enum logic {ST_IDLE, ST_POP} state_e;

  state_e                  state_q, state_d;
  logic [PW-1:0]           wp_q, wp_d, rp_q, rp_d, wp_next, rp_next;
  logic [PAYLOAD_BITS-1:0] cur_data_q, cur_data_d;
  logic [KIND_W-1:0]       cur_kind_q, cur_kind_d;
  logic [COUNT_W-1:0]      retries_q, retries_d;
  logic [COUNT_W-1:0]      sent_q, sent_d;
  logic [COUNT_W-1:0]      credit_q, credit_d;
  logic [LIMIT_W-1:0]      retry_limit_q;
  logic [COUNT_W-1:0]      credit_def_q, credit_drop_q;

  logic                    ram_we, ram_re;
  logic [EW-1:0]           ram_rdata;
  logic                    retry_pend, q_empty, need_pop, pending;

  assign wp_next    = (wp_q == PTR_LAST) ? '0 : wp_q + PW'(1);
  assign rp_next    = (rp_q == PTR_LAST) ? '0 : rp_q + PW'(1);
  assign q_empty    = (wp_q == rp_q);
  assign retry_pend = (retries_q != RETRY_IDLE) && (retries_q != '0);
  assign need_pop   = cmd_valid_i && (cmd_i.op == CMD_SEND) && (credit_q != '0) &&
                      !retry_pend && !q_empty && (retries_q == RETRY_IDLE);

  rqcrs_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({cmd_i.report_kind, cmd_i.report_data[PAYLOAD_BITS-1:0]}),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    cur_data_d = cur_data_q;
    cur_kind_d = cur_kind_q;
    retries_d  = retries_q;
    sent_d     = sent_q;
    credit_d   = credit_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    pending    = 1'b0;
    res_o      = '0;
    if (cmd_valid_i && !res_full_i) begin
      if (state_q == ST_IDLE && need_pop) begin
        ram_re  = 1'b1;
        state_d = ST_POP;
      end else begin
        cmd_pop_o  = 1'b1;
        res_push_o = 1'b1;
        state_d    = ST_IDLE;
        case (cmd_i.op)
          CMD_ENQ: begin
            if (wp_next != rp_q) begin
              ram_we                 = 1'b1;
              wp_d                   = wp_next;
              res_o.enqueue_accepted = 1'b1;
            end
          end
          CMD_SEND: begin
            if (credit_q != '0) begin
              if (retry_pend) begin
                retries_d = retries_q - COUNT_W'(1);
                pending   = 1'b1;
              end else if (state_q == ST_POP) begin
                cur_data_d = ram_rdata[PAYLOAD_BITS-1:0];
                cur_kind_d = ram_rdata[EW-1:PAYLOAD_BITS];
                rp_d       = rp_next;
                pending    = (ram_rdata[EW-1:PAYLOAD_BITS] != KIND_NONE);
              end
            end
            if (pending) begin
              res_o.send_valid = 1'b1;
              res_o.send_kind  = cur_kind_d;
              res_o.send_data  = DATA_W'(cur_data_d);
              if (cmd_i.send_outcome == OUTC_OK) begin
                sent_d    = sent_q + COUNT_W'(1);
                credit_d  = credit_q - COUNT_W'(1);
                retries_d = RETRY_IDLE;
              end else begin
                if (cmd_i.send_outcome == OUTC_BUSY) begin
                  credit_d = '0;
                end
                if (retries_d == RETRY_IDLE) begin
                  retries_d = COUNT_W'(retry_limit_q);
                end
              end
              if (retries_d == '0) begin
                retries_d            = RETRY_IDLE;
                cur_data_d           = '0;
                cur_kind_d           = KIND_NONE;
                credit_d             = credit_drop_q;
                res_o.report_dropped = 1'b1;
              end
            end
          end
          CMD_UNACK: begin
            if (cmd_i.unacked_count == '0) begin
              sent_d   = '0;
              credit_d = credit_def_q;
            end else if (cmd_i.unacked_count < sent_q) begin
              credit_d = sent_q - cmd_i.unacked_count;
              sent_d   = cmd_i.unacked_count;
            end
          end
          default: ;
        endcase
        res_o.work_waiting = (wp_d != rp_d) ||
                             ((retries_d != RETRY_IDLE) && (retries_d != '0));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wp_q          <= '0;
      rp_q          <= '0;
      cur_data_q    <= '0;
      cur_kind_q    <= KIND_NONE;
      retries_q     <= RETRY_IDLE;
      sent_q        <= '0;
      credit_q      <= CREDIT_DEFAULT_RST;
      retry_limit_q <= RETRY_LIMIT_RST;
      credit_def_q  <= CREDIT_DEFAULT_RST;
      credit_drop_q <= CREDIT_DROP_RST;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      cur_data_q <= cur_data_d;
      cur_kind_q <= cur_kind_d;
      retries_q  <= retries_d;
      sent_q     <= sent_d;
      credit_q   <= credit_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RETRY_LIMIT:    retry_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_CREDIT_DEFAULT: credit_def_q  <= cfg_wdata_i;
          CFG_CREDIT_DROP:    credit_drop_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  a_pop_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> res_push_o && cmd_pop_o)
    else $error("ring read not followed by command completion");

  a_drop_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.report_dropped |-> res_o.send_valid)
    else $error("drop reported without a send");

  a_send_needs_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.send_valid |-> credit_q != '0)
    else $error("send issued with zero credit");

  a_retry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retries_q != RETRY_IDLE |-> !retries_q[COUNT_W-1])
    else $error("retry counter out of range");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> state_q == ST_POP)
    else $error("ring read without pop state");

endmodule

// ----- sv/rqcrs_outq.sv -----
// Result queue: two-entry buffer between the back end and the result port.
// Depends on rqcrs_pkg.
module rqcrs_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rqcrs_pkg::out_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output rqcrs_pkg::out_item_t item_o
);
  import rqcrs_pkg::*;

  out_item_t  buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- sv/report_queue_credit_retry_sender_top.sv -----
// Top level of the report queue with credit-limited retrying sender.
// Depends on rqcrs_pkg, rqcrs_front, rqcrs_back, rqcrs_outq.
//
// Usage:
//   Input side is a queue: an item is taken when push is high and full is low.
//   Result side is a queue: while empty is low the oldest result is on
//   out_item_o; it is taken when pop is high. Every item yields one result.
//   Configuration: cfg_we_i writes cfg_wdata_i into the register selected by
//   cfg_idx_i (retry limit, default credit, credit after drop); write only
//   while no item is in flight.
// Timing:
//   A send that takes a new report from the ring waits in the pop state for the
//   registered read of the ring memory; every other item completes as the back
//   end sees it, so up to one item per cycle while the result queue has room.
// Reset:
//   Ring empty, retry idle, sent count zero, credit and registers at defaults.
// Stall:
//   The result queue holds two results; when it fills the back end holds,
//   the two-entry command queue fills and full rises until pop drains it.
module report_queue_credit_retry_sender_top #(
  parameter int unsigned QUEUE_DEPTH  = rqcrs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = rqcrs_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rqcrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rqcrs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  rqcrs_pkg::in_item_t              in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output rqcrs_pkg::out_item_t             out_item_o
);
  import rqcrs_pkg::*;

  logic      cmd_valid, cmd_pop, res_full, res_push;
  cmd_t      cmd;
  out_item_t res;

  rqcrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rqcrs_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  rqcrs_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (out_item_o)
  );

endmodule

// ----- tb/tb_report_queue_credit_retry_sender_top.sv -----
// Self-checking testbench for report_queue_credit_retry_sender_top; depends on rqcrs_pkg and the DUT.
// A directed table runs first, then random phases with different register settings.
// Every result is checked against a behavioral predictor or a pinned value from the table.
module tb_report_queue_credit_retry_sender_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rqcrs_pkg::*;

  localparam int          PTR_W       = $clog2(QUEUE_DEPTH_DEF);
  localparam int          LIMIT       = 800000;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [1:0]  OUTC_CODE3  = 2'd3;
  localparam logic [1:0]  KIND_KBD    = 2'd1;
  localparam logic [1:0]  KIND_CONS   = 2'd2;
  localparam logic [1:0]  KIND_MOUSE  = 2'd3;
  localparam logic [63:0] ONES        = {64{1'b1}};

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t res;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  push;
  logic                  full;
  in_item_t              in_item_i;
  logic                  empty;
  logic                  pop;
  out_item_t             out_item_o;

  report_queue_credit_retry_sender_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // predictor state
  logic [DATA_W-1:0]  ring_data [QUEUE_DEPTH_DEF];
  logic [KIND_W-1:0]  ring_kind [QUEUE_DEPTH_DEF];
  logic [PTR_W-1:0]   wr_ptr    = '0;
  logic [PTR_W-1:0]   rd_ptr    = '0;
  logic [DATA_W-1:0]  cur_data  = '0;
  logic [KIND_W-1:0]  cur_kind  = KIND_NONE;
  logic [COUNT_W-1:0] retry_cnt = RETRY_IDLE;
  logic [COUNT_W-1:0] sent_cnt  = '0;
  logic [COUNT_W-1:0] credit    = CREDIT_DEFAULT_RST;
  logic [LIMIT_W-1:0] lim_retry = RETRY_LIMIT_RST;
  logic [COUNT_W-1:0] cred_dflt = CREDIT_DEFAULT_RST;
  logic [COUNT_W-1:0] cred_drop = CREDIT_DROP_RST;

  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];
  bit        pin_fixed;
  out_item_t pin_res;
  int        errors     = 0;
  int        acc_cnt    = 0;
  int        res_cnt    = 0;
  int        refusals   = 0;
  int        drops      = 0;
  int        send_idle  = 0;
  int        recv_stall = 0;
  int        enq_pct    = 35;
  bit        hold_req   = 1'b0;

  function automatic out_item_t predict_report(in_item_t it);
    out_item_t        o;
    logic             go;
    logic [PTR_W-1:0] nxt;
    o  = '0;
    go = 1'b0;
    case (it.func)
      FUNC_ENQ: begin
        nxt = wr_ptr + 1'b1;
        if (nxt != rd_ptr) begin
          ring_data[wr_ptr] = it.report_data;
          ring_kind[wr_ptr] = it.report_kind;
          wr_ptr = nxt;
          o.enqueue_accepted = 1'b1;
        end else begin
          refusals++;
        end
      end
      FUNC_SEND: begin
        if (it.link_up) begin
          if (credit != '0) begin
            if (retry_cnt != RETRY_IDLE && retry_cnt != '0) begin
              retry_cnt--;
              go = 1'b1;
            end else if (wr_ptr != rd_ptr && retry_cnt == RETRY_IDLE) begin
              cur_data = ring_data[rd_ptr];
              cur_kind = ring_kind[rd_ptr];
              rd_ptr++;
              go = (cur_kind != KIND_NONE);
            end
          end
          if (go) begin
            o.send_valid = 1'b1;
            o.send_kind  = cur_kind;
            o.send_data  = cur_data;
            if (it.send_outcome == OUTC_OK) begin
              sent_cnt++;
              if (credit != '0) credit--;
              retry_cnt = RETRY_IDLE;
            end else begin
              if (it.send_outcome == OUTC_BUSY) credit = '0;
              if (retry_cnt == RETRY_IDLE) retry_cnt = {1'b0, lim_retry};
            end
            if (retry_cnt == '0) begin
              retry_cnt = RETRY_IDLE;
              cur_data  = '0;
              cur_kind  = KIND_NONE;
              credit    = cred_drop;
              o.report_dropped = 1'b1;
              drops++;
            end
          end
        end
      end
      FUNC_UNACK: begin
        if (it.link_up) begin
          if (it.unacked_count == '0) begin
            sent_cnt = '0;
            credit   = cred_dflt;
          end else if (it.unacked_count < sent_cnt) begin
            credit   = sent_cnt - it.unacked_count;
            sent_cnt = it.unacked_count;
          end
        end
      end
      default: ;
    endcase
    o.work_waiting = (wr_ptr != rd_ptr) || (retry_cnt != RETRY_IDLE && retry_cnt != '0);
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  function automatic in_item_t stim(logic [1:0] f, logic [1:0] k, logic [63:0] d,
                                    logic up, logic [1:0] oc, logic [7:0] un);
    in_item_t it;
    it.func          = f;
    it.report_kind   = k;
    it.report_data   = d;
    it.link_up       = up;
    it.send_outcome  = oc;
    it.unacked_count = un;
    return it;
  endfunction

  function automatic out_item_t res(logic acc, logic vld, logic [1:0] k, logic [63:0] d,
                                    logic drp, logic wt);
    out_item_t o;
    o.enqueue_accepted = acc;
    o.send_valid       = vld;
    o.send_kind        = k;
    o.send_data        = d;
    o.report_dropped   = drp;
    o.work_waiting     = wt;
    return o;
  endfunction

  function automatic in_item_t rand_item(int enq);
    in_item_t it;
    int       r;
    it.report_kind = 2'($urandom_range(3));
    it.report_data = {$urandom, $urandom};
    it.link_up     = ($urandom_range(99) < 90);
    r = $urandom_range(99);
    it.send_outcome = (r < 60) ? OUTC_OK : (r < 78) ? OUTC_BUSY : (r < 94) ? OUTC_ERR : OUTC_CODE3;
    r = $urandom_range(99);
    it.unacked_count = (r < 30) ? 8'd0 : (r < 80) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < enq) begin
      it.func = FUNC_ENQ;
    end else begin
      r = $urandom_range(99);
      it.func = (r < 70) ? FUNC_SEND : (r < 92) ? FUNC_UNACK : FUNC_UNUSED;
    end
    return it;
  endfunction

  // offer one beat; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it, bit fx, out_item_t rs);
    while ($urandom_range(99) < send_idle) begin
      push      <= 1'b0;
      in_item_i <= rand_item(enq_pct);
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    pin_fixed <= fx;
    pin_res   <= rs;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic wait_quiet(int extra);
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [6:0] lim, logic [7:0] cdef, logic [7:0] cdrop);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RETRY_LIMIT;
    cfg_wdata_i <= {1'b0, lim};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CREDIT_DEFAULT;
    cfg_wdata_i <= cdef;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CREDIT_DROP;
    cfg_wdata_i <= cdrop;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_retry = lim;
    cred_dflt = cdef;
    cred_drop = cdrop;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [6:0] lim, logic [7:0] cdef, logic [7:0] cdrop,
                           int s_idle, int r_stall, int enq, int n, bit squeeze);
    wait_quiet(4);
    set_regs(lim, cdef, cdrop);
    send_idle  = s_idle;
    recv_stall = r_stall;
    enq_pct    = enq;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == 100) hold_req = 1'b1;
      send_item(rand_item(enq), 1'b0, '0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = 300;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    out_item_t p;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("enqueue_accepted", 64'(want.enqueue_accepted),
                      64'(out_item_o.enqueue_accepted));
          check_field("send_valid", 64'(want.send_valid), 64'(out_item_o.send_valid));
          check_field("send_kind", 64'(want.send_kind), 64'(out_item_o.send_kind));
          check_field("send_data", 64'(want.send_data), 64'(out_item_o.send_data));
          check_field("report_dropped", 64'(want.report_dropped),
                      64'(out_item_o.report_dropped));
          check_field("work_waiting", 64'(want.work_waiting), 64'(out_item_o.work_waiting));
          res_cnt++;
        end
      end
      if (push && !full) begin
        p = predict_report(in_item_i);
        pending_results.push_back(pin_fixed ? pin_res : p);
        acc_cnt++;
      end
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("tb_report_queue_credit_retry_sender_top failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_RETRY_LIMIT;
    cfg_wdata_i = '0;
    in_item_i   = '0;
    pin_fixed   = 1'b0;
    pin_res     = '0;

    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{stim(FUNC_UNUSED, KIND_MOUSE, ONES, 1, OUTC_OK, 255), 1,
                         res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{stim(FUNC_UNACK, KIND_NONE, '0, 1, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{stim(FUNC_ENQ, KIND_KBD, ONES, 0, OUTC_OK, 0), 1, res(1, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_ENQ, KIND_MOUSE, '0, 1, OUTC_OK, 0), 1, res(1, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 0, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_UNACK, KIND_NONE, '0, 0, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 1,
                         res(0, 1, KIND_KBD, ONES, 0, 1)});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_BUSY, 0), 1,
                         res(0, 1, KIND_MOUSE, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_UNACK, KIND_NONE, '0, 1, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_ERR, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_CODE3, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_ERR, 0), 1,
                         res(0, 1, KIND_MOUSE, 0, 1, 0)});
    dir_rows.push_back('{stim(FUNC_ENQ, KIND_NONE, 64'h0123_4567_89ab_cdef, 1, OUTC_OK, 0), 1,
                         res(1, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 1, res(0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{stim(FUNC_ENQ, KIND_CONS, 64'h8000_0000_0000_0001, 1, OUTC_OK, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_ENQ, KIND_KBD, 64'h5a5a_a5a5_5a5a_a5a5, 1, OUTC_OK, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_UNACK, KIND_NONE, '0, 1, OUTC_OK, 1), 0, '0});
    dir_rows.push_back('{stim(FUNC_UNACK, KIND_NONE, '0, 1, OUTC_OK, 255), 0, '0});
    dir_rows.push_back('{stim(FUNC_ENQ, KIND_MOUSE, 64'hfedc_ba98_7654_3210, 1, OUTC_OK, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 0, '0});
    dir_rows.push_back('{stim(FUNC_SEND, KIND_NONE, '0, 1, OUTC_OK, 0), 0, '0});

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle  = 10;
    recv_stall = 10;
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);

    run_phase(7'd127, 8'd255, 8'd255, 0, 0, 35, 400, 1'b1);
    run_phase(7'd1, 8'd1, 8'd0, 85, 0, 35, 300, 1'b0);
    run_phase(7'd0, 8'd0, 8'd1, 0, 85, 35, 300, 1'b0);
    run_phase(7'd5, 8'd16, 8'd8, 10, 10, 35, 400, 1'b0);
    run_phase(7'd2, 8'd255, 8'd255, 0, 0, 85, 300, 1'b0);
    run_phase(7'd127, 8'd200, 8'd3, 10, 10, 35, 300, 1'b0);
    wait_quiet(20);

    $display("%0d beats accepted, %0d results checked over the directed table and six phases",
             acc_cnt, res_cnt);
    $display("%0d enqueues refused on a full ring, %0d reports dropped after retries",
             refusals, drops);
    if (errors == 0) begin
      $display("tb_report_queue_credit_retry_sender_top passed");
    end else begin
      $display("tb_report_queue_credit_retry_sender_top failed");
    end
    $finish;
  end

endmodule

// ----- report_queue_credit_retry_sender_top.f -----
sv/rqcrs_pkg.sv
sv/rqcrs_ram.sv
sv/rqcrs_front.sv
sv/rqcrs_back.sv
sv/rqcrs_outq.sv
sv/report_queue_credit_retry_sender_top.sv
tb/tb_report_queue_credit_retry_sender_top.sv
